// ===== src/crc8_checked_frame_sync_core_macros.svh =====
// ---------------------------------------------------------------------------
// crc8_checked_frame_sync_core_macros.svh
// Assertion macros used by the frame sync core module.
// ---------------------------------------------------------------------------
`ifndef CRC8_CHECKED_FRAME_SYNC_CORE_MACROS_SVH
`define CRC8_CHECKED_FRAME_SYNC_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define C8FS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define C8FS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/c8fs_pkg.sv =====
// ---------------------------------------------------------------------------
// c8fs_pkg
// Types, constants and the CRC-8 byte step for the frame sync core.
// ---------------------------------------------------------------------------
package c8fs_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h3A;
  localparam logic [7:0] CRC_POLY   = 8'h31;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [2:0] FRAME_GAP  = 3'd4;

  typedef enum logic {
    KIND_FRAME   = 1'b0,
    KIND_CRC_ERR = 1'b1
  } c8fs_kind_t;

  typedef struct packed {
    c8fs_kind_t  kind;
    logic [6:0]  tag;
    logic [15:0] value;
  } c8fs_result_t;

  typedef struct packed {
    logic         valid;
    c8fs_result_t result;
    logic [2:0]   skip;
  } c8fs_status_t;

  // one byte through CRC-8, MSB first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/crc8_checked_frame_sync_core.sv =====
// ---------------------------------------------------------------------------
// crc8_checked_frame_sync_core
// Header-synchronized deframer with CRC-8 (poly 0x31, init 0xFF) check.
//
// Input stream: one received byte per transaction on s_tdata.
// Output stream: at most one result per input byte. m_tuser is the kind
// (0 good frame, 1 header seen but CRC mismatch); m_tdata carries the tag
// (low 7 bits) and the 16-bit data. Error results carry zero fields.
// Frames are 5 bytes: 0x3A, tag, data low, data high, CRC over the middle
// three. After a good frame its remaining bytes are not window starts.
// The result for a byte is registered and appears in the cycle after that
// byte is accepted. Throughput: one byte per cycle while the receiver keeps
// up; CRC partials are kept per byte so the check is one compare on the new byte.
// Reset clears the window to zero and skips the first four bytes.
// When the receiver stalls, the output register holds its result and
// s_tready drops until the result is taken.
// ---------------------------------------------------------------------------
`include "crc8_checked_frame_sync_core_macros.svh"

module crc8_checked_frame_sync_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [6:0] tag, [22:7] frame_value, [23] zero
  output logic [0:0]  m_tuser    // [0] kind
);
  import c8fs_pkg::*;

  logic         s_fire;
  logic [7:0]   crc3;
  c8fs_status_t status;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;

  c8fs_crc_pipe u_crc (
    .clk     (clk),
    .accept  (s_fire),
    .rx_byte (s_tdata),
    .crc3    (crc3)
  );

  c8fs_window u_window (
    .clk     (clk),
    .rst     (rst),
    .accept  (s_fire),
    .rx_byte (s_tdata),
    .crc3    (crc3),
    .status  (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= status.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {1'b0, status.result.value, status.result.tag};
      m_tuser <= status.result.kind;
    end
  end

  `C8FS_ASSERT_NEXT(a_gap_after_frame, s_fire && status.valid && status.result.kind == KIND_FRAME, status.skip == FRAME_GAP, "skip not reloaded after good frame")
  `C8FS_ASSERT_SAME(a_err_fields_zero, m_tvalid && m_tuser[0], m_tdata == 24'd0, "error result has nonzero fields")
  `C8FS_ASSERT_SAME(a_stall_only_full, !s_tready, m_tvalid, "input stalled with empty output")

endmodule

// ===== src/c8fs_crc_pipe.sv =====
// ---------------------------------------------------------------------------
// c8fs_crc_pipe
// Running CRC-8 over the last one, two and three accepted bytes.
// ---------------------------------------------------------------------------
module c8fs_crc_pipe (
  input  logic       clk,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic [7:0] crc3
);
  import c8fs_pkg::*;

  logic [7:0] crc1;
  logic [7:0] crc2;

  always_ff @(posedge clk) begin
    if (accept) begin
      crc1 <= crc_feed(CRC_INIT, rx_byte);
      crc2 <= crc_feed(crc1, rx_byte);
      crc3 <= crc_feed(crc2, rx_byte);
    end
  end

endmodule

// ===== src/c8fs_window.sv =====
// ---------------------------------------------------------------------------
// c8fs_window
// Byte window, skip counter and frame decision.
// ---------------------------------------------------------------------------
module c8fs_window (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         crc3,
  output c8fs_pkg::c8fs_status_t status
);
  import c8fs_pkg::*;

  logic [7:0] recent [4];
  logic [2:0] skip;
  logic [2:0] skip_next;
  logic       hit;
  logic       crc_ok;

  assign hit    = (skip == 3'd0) && (recent[0] == HDR_BYTE);
  assign crc_ok = (crc3 == rx_byte);

  always_comb begin
    status.valid        = hit;
    status.skip         = skip;
    status.result.kind  = crc_ok ? KIND_FRAME : KIND_CRC_ERR;
    status.result.tag   = crc_ok ? recent[1][6:0] : 7'd0;
    status.result.value = crc_ok ? {recent[3], recent[2]} : 16'd0;
  end

  always_comb begin
    skip_next = skip;
    priority if (skip != 3'd0) begin
      skip_next = skip - 3'd1;
    end else if (hit && crc_ok) begin
      skip_next = FRAME_GAP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip <= FRAME_GAP;
      for (int k = 0; k < 4; k++) recent[k] <= 8'd0;
    end else if (accept) begin
      skip      <= skip_next;
      recent[0] <= recent[1];
      recent[1] <= recent[2];
      recent[2] <= recent[3];
      recent[3] <= rx_byte;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Stream-level check of the CRC-8 frame sync core. Received bytes are fed
// through the slave stream with random gaps; every accepted byte runs
// through a local copy of the deframer state (byte window and skip count)
// and the results it should cause are queued. Results on the master stream
// are matched in order, field by field. The byte mix is mostly well-formed
// frames with random content, plus corrupted CRCs, cut-off frames, stray
// headers and noise. One long receiver stall fills the core; the sender
// also stops after each phase until the core has drained.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import c8fs_pkg::*;

  typedef struct {
    logic [7:0] b;
    int         gap;
  } rx_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;

  crc8_checked_frame_sync_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  rx_item_t     pending_bytes[$];
  c8fs_result_t expected_results[$];

  // local deframer state
  logic [7:0] last_bytes [4];
  logic [2:0] skip_left;

  int n_pushed   = 0;
  int n_accepted = 0;
  int n_results  = 0;
  int n_good     = 0;
  int n_crc_err  = 0;
  int errors     = 0;

  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit rx_hold    = 1'b0;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic logic [7:0] frame_crc(input logic [7:0] tag, input logic [7:0] lo,
                                           input logic [7:0] hi);
    return crc8_next(crc8_next(crc8_next(CRC_INIT, tag), lo), hi);
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    c8fs_result_t r;
    if (skip_left != 3'd0) begin
      skip_left = skip_left - 3'd1;
    end else if (last_bytes[0] == HDR_BYTE) begin
      if (frame_crc(last_bytes[1], last_bytes[2], last_bytes[3]) == b) begin
        r.kind    = KIND_FRAME;
        r.tag     = last_bytes[1][6:0];
        r.value   = {last_bytes[3], last_bytes[2]};
        skip_left = FRAME_GAP;
      end else begin
        r.kind  = KIND_CRC_ERR;
        r.tag   = 7'd0;
        r.value = 16'd0;
      end
      expected_results.insert(expected_results.size(), r);
    end
    last_bytes[0] = last_bytes[1];
    last_bytes[1] = last_bytes[2];
    last_bytes[2] = last_bytes[3];
    last_bytes[3] = b;
  endtask

  task automatic push_byte(input logic [7:0] b, input int gap);
    rx_item_t it;
    it.b   = b;
    it.gap = gap;
    pending_bytes.insert(pending_bytes.size(), it);
    n_pushed++;
  endtask

  function automatic int draw_gap(input bit on);
    if (!on || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 12);
  endfunction

  // corrupt != 0 flips CRC bits
  task automatic push_frame(input logic [7:0] tag, input logic [15:0] value,
                            input logic [7:0] corrupt, input bit idle);
    push_byte(HDR_BYTE, draw_gap(idle));
    push_byte(tag, draw_gap(idle));
    push_byte(value[7:0], draw_gap(idle));
    push_byte(value[15:8], draw_gap(idle));
    push_byte(frame_crc(tag, value[7:0], value[15:8]) ^ corrupt, draw_gap(idle));
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 9) == 0) return HDR_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic gen_stream(input int n_bytes);
    int start;
    int pick;
    int cnt;
    int items;
    start = n_pushed;
    items = 0;
    while (n_pushed - start < n_bytes) begin
      if (items % 25 == 0) tx_idle_on = ($urandom_range(0, 2) != 0);
      items++;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        push_frame(rand_byte(), {rand_byte(), rand_byte()}, 8'h00, tx_idle_on);
      end else if (pick < 75) begin
        push_frame(rand_byte(), {rand_byte(), rand_byte()}, 8'($urandom_range(1, 255)),
                   tx_idle_on);
      end else if (pick < 85) begin
        cnt = $urandom_range(1, 3);
        push_byte(HDR_BYTE, draw_gap(tx_idle_on));
        repeat (cnt) push_byte(rand_byte(), draw_gap(tx_idle_on));
      end else if (pick < 90) begin
        push_byte(HDR_BYTE, draw_gap(tx_idle_on));
      end else begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) push_byte(8'($urandom_range(0, 255)), draw_gap(tx_idle_on));
      end
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_pushed || expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // input side: predict on every accepted byte
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      deframe_byte(s_tdata);
      n_accepted++;
    end
  end

  // output side: compare against oldest expectation
  always @(posedge clk) begin : result_check
    c8fs_result_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (m_tuser[0] == KIND_FRAME) n_good++;
      else n_crc_err++;
      if (expected_results.size() == 0) begin
        errors++;
        $error("unexpected result: kind %0d tag 0x%02h value 0x%04h",
               m_tuser[0], m_tdata[6:0], m_tdata[22:7]);
      end else begin
        e = expected_results.pop_front();
        if (m_tuser[0] !== e.kind) begin
          errors++;
          $error("kind: expected %0d, actual %0d", e.kind, m_tuser[0]);
        end
        if (m_tdata[6:0] !== e.tag) begin
          errors++;
          $error("tag: expected 0x%02h, actual 0x%02h", e.tag, m_tdata[6:0]);
        end
        if (m_tdata[22:7] !== e.value) begin
          errors++;
          $error("frame_value: expected 0x%04h, actual 0x%04h", e.value, m_tdata[22:7]);
        end
        if (m_tdata[23] !== 1'b0) begin
          errors++;
          $error("pad: expected 0, actual %0b", m_tdata[23]);
        end
      end
    end
  end

  // sender
  int tx_seen = 0;
  always @(negedge clk) begin : byte_driver
    logic       nv;
    logic [7:0] nd;
    nv = s_tvalid;
    nd = s_tdata;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (n_accepted != tx_seen) begin
        tx_seen = n_accepted;
        nv      = 1'b0;
      end
      if (!nv && pending_bytes.size() != 0) begin
        if (pending_bytes[0].gap > 0) begin
          pending_bytes[0].gap--;
        end else begin
          nd = pending_bytes.pop_front().b;
          nv = 1'b1;
        end
      end
    end
    s_tvalid <= nv;
    s_tdata  <= nd;
  end

  // receiver
  int rx_seen = 0;
  int rx_wait = 0;
  always @(negedge clk) begin
    if (n_results != rx_seen) begin
      rx_seen = n_results;
      if (rx_seen % 40 == 0) rx_idle_on = $urandom_range(0, 1);
      rx_wait = draw_gap(rx_idle_on);
    end
    m_tready <= !rx_hold && (rx_wait == 0);
    if (rx_wait != 0) rx_wait--;
  end

  // long receiver stall while bytes keep coming
  initial begin
    wait (n_accepted >= 400);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (300) @(posedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL crc8_checked_frame_sync_core");
    $finish;
  end

  initial begin
    for (int k = 0; k < 4; k++) last_bytes[k] = 8'h00;
    skip_left = FRAME_GAP;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: first frame right after reset, tag MSB set, all-ones data
    push_frame(8'h85, 16'hFFFF, 8'h00, 1'b0);
    // headers inside the skipped span
    push_frame(HDR_BYTE, {HDR_BYTE, HDR_BYTE}, 8'h00, 1'b0);
    // bad CRC, then resync on a frame starting one byte later
    push_frame(8'h00, 16'h0000, 8'h01, 1'b0);
    push_byte(HDR_BYTE, 0);
    push_frame(8'h12, 16'h8001, 8'h00, 1'b0);
    // noise
    push_byte(8'h00, 0);
    push_byte(8'hFF, 0);
    push_frame(8'h7F, 16'h0000, 8'h00, 1'b0);
    wait_drained();

    gen_stream(800);
    wait_drained();
    gen_stream(820);
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Fed %0d bytes with frames, bad CRCs, cut-off frames and noise;", n_accepted);
    $display("checked %0d good frames and %0d CRC error reports.", n_good, n_crc_err);
    if (errors == 0) begin
      $display("PASS crc8_checked_frame_sync_core");
    end else begin
      $display("FAIL crc8_checked_frame_sync_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/c8fs_pkg.sv
src/c8fs_crc_pipe.sv
src/c8fs_window.sv
src/crc8_checked_frame_sync_core.sv
verif/testbench.sv
